/* src/wsa_pkg.sv */
// wsa_pkg: shared types and constants of the wilder smoothing average block
// used by wsa_arith and wilder_smoothing_average; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package wsa_pkg;

  localparam int PERIOD_W  = 16;
  localparam int SEEN_W    = 17;
  localparam int INDEX_W   = 32;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_PERIOD   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_UNSTABLE = 1'b1;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET   = 16'd14;
  localparam logic [PERIOD_W-1:0] UNSTABLE_RESET = 16'd0;

  // operations of the shared add/subtract unit
  typedef logic [2:0] wsa_op_t;
  localparam wsa_op_t OP_NONE = 3'd0;
  localparam wsa_op_t OP_SEED = 3'd1;  // seed sum plus sample
  localparam wsa_op_t OP_MAC  = 3'd2;  // one shift-add multiply step
  localparam wsa_op_t OP_ADDX = 3'd3;  // product plus sample
  localparam wsa_op_t OP_MAG  = 3'd4;  // magnitude plus half period
  localparam wsa_op_t OP_DIV  = 3'd5;  // restoring divide trial subtract
  localparam wsa_op_t OP_NEG  = 3'd6;  // apply sign to quotient

  typedef struct packed {
    wsa_op_t op;
    logic    neg;   // operand is negative: subtract instead of add
    logic    mbit;  // current multiplier bit
  } wsa_ctl_t;

endpackage

`default_nettype wire

/* src/wsa_arith.sv */
// wsa_arith: shared add/subtract unit with per-operation operand selection
// depends on wsa_pkg
`timescale 1ns / 1ps
`default_nettype none

module wsa_arith
  import wsa_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 32
) (
  input  wire wsa_ctl_t                     ctl,
  input  wire logic [SAMPLE_WIDTH+15:0]     acc,
  input  wire logic [SAMPLE_WIDTH+15:0]     mcand,
  input  wire logic [SAMPLE_WIDTH+15:0]     seed_sum,
  input  wire logic [SAMPLE_WIDTH-1:0]      x,
  input  wire logic [SAMPLE_WIDTH-1:0]      quo,
  input  wire logic [PERIOD_W-1:0]          rem,
  input  wire logic                         dbit,
  input  wire logic [PERIOD_W-1:0]          period,
  output logic      [SAMPLE_WIDTH+16:0]     y
);

  localparam int SW    = SAMPLE_WIDTH;
  localparam int SUM_W = SW + 16;
  localparam int ALU_W = SUM_W + 1;

  logic [ALU_W-1:0] a;
  logic [ALU_W-1:0] b;
  logic [ALU_W-1:0] b_inv;
  logic             sub;

  always_comb begin
    a   = '0;
    b   = '0;
    sub = 1'b0;
    case (ctl.op)
      OP_SEED: begin
        a = {seed_sum[SUM_W-1], seed_sum};
        b = {{(ALU_W-SW){x[SW-1]}}, x};
      end
      OP_MAC: begin
        a = {acc[SUM_W-1], acc};
        b = ctl.mbit ? {mcand[SUM_W-1], mcand} : '0;
      end
      OP_ADDX: begin
        a = {acc[SUM_W-1], acc};
        b = {{(ALU_W-SW){x[SW-1]}}, x};
      end
      OP_MAG: begin
        // |acc| + period/2 as half - acc or half + acc
        a   = {{(ALU_W-PERIOD_W+1){1'b0}}, period[PERIOD_W-1:1]};
        b   = {acc[SUM_W-1], acc};
        sub = ctl.neg;
      end
      OP_DIV: begin
        a   = {{(ALU_W-PERIOD_W-1){1'b0}}, rem, dbit};
        b   = {{(ALU_W-PERIOD_W){1'b0}}, period};
        sub = 1'b1;
      end
      OP_NEG: begin
        a   = '0;
        b   = {{(ALU_W-SW){1'b0}}, quo};
        sub = ctl.neg;
      end
      default: begin
        a   = '0;
        b   = '0;
        sub = 1'b0;
      end
    endcase
  end

  assign b_inv = sub ? ~b : b;
  assign y     = a + b_inv + {{(ALU_W-1){1'b0}}, sub};

endmodule

`default_nettype wire

/* src/wilder_smoothing_average.sv */
// wilder_smoothing_average: Wilder smoothed moving average over a sample stream
// sequencer, series state and output register; uses wsa_pkg and wsa_arith
//
// usage: one signed sample per request on the in_ channel, with in_restart
// marking the first sample of a new series. cfg_we/cfg_index/cfg_wdata write
// period (index 0) and unstable_bars (index 1); the user writes them only
// while the block is idle, which the block does not enforce. the first
// period-1+unstable_bars samples of a series give no result; each later one
// gives one request on the out_ channel with its smoothed value and index.
// timing: in_stall is high while a sample is in work. a sample still in the
// seed phase only adds to the seed sum; one that completes the seed passes
// the magnitude step, the divide and the sign step; a later one first takes
// 16 shift-add multiply steps by period-1 and adds the sample, all on the
// shared add/subtract unit, then the same steps with one restoring divide
// step per result bit; a sample that gives a result ends in the emit state.
// results sit in an output register; the next sample is taken while it waits.
// if the receiver stalls, a following result waits in the sequencer.
// reset: period is 14, unstable_bars 0, the series state is clear and no
// result is pending.
`timescale 1ns / 1ps
`default_nettype none

module wilder_smoothing_average
  import wsa_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic signed [SAMPLE_WIDTH-1:0] in_sample,
  input  wire logic                       in_restart,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]  out_smoothed,
  output logic [INDEX_W-1:0]              out_out_index,
  input  wire logic                       cfg_we,
  input  wire logic [CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [PERIOD_W-1:0]        cfg_wdata
);

  localparam int SW    = SAMPLE_WIDTH;
  localparam int SUM_W = SW + 16;
  localparam int ALU_W = SUM_W + 1;
  localparam int CNT_W = $clog2(SW + 1);

  localparam logic [CNT_W-1:0] MUL_STEPS = CNT_W'(PERIOD_W);
  localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(SW);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_START = 4'd1;
  localparam logic [3:0] S_MUL   = 4'd2;
  localparam logic [3:0] S_ADDX  = 4'd3;
  localparam logic [3:0] S_MAG   = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_NEG   = 4'd6;
  localparam logic [3:0] S_EMIT  = 4'd7;

  logic [3:0]          state_r, state_nxt;
  logic [PERIOD_W-1:0] period_r, period_nxt;
  logic [PERIOD_W-1:0] unstable_r, unstable_nxt;
  logic [SEEN_W-1:0]   seen_r, seen_nxt;
  logic [INDEX_W-1:0]  results_r, results_nxt;
  logic [SW-1:0]       avg_r, avg_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [SW-1:0]       out_sm_r, out_sm_nxt;
  logic [INDEX_W-1:0]  out_idx_r, out_idx_nxt;
  logic [SW-1:0]       x_r, x_nxt;
  logic [SUM_W-1:0]    acc_r, acc_nxt;
  logic [SUM_W-1:0]    mcand_r, mcand_nxt;
  logic [PERIOD_W-1:0] mplier_r, mplier_nxt;
  logic [PERIOD_W-1:0] rem_r, rem_nxt;
  logic [SW-1:0]       quo_r, quo_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                neg_r, neg_nxt;
  logic                emit_r, emit_nxt;

  logic [PERIOD_W-1:0] p_eff;
  logic [SEEN_W-1:0]   p17;
  logic [SEEN_W-1:0]   goal;
  wsa_ctl_t            ctl;
  logic [ALU_W-1:0]    y;

  // a period of zero behaves as one
  assign p_eff = (period_r == '0) ? {{(PERIOD_W-1){1'b0}}, 1'b1} : period_r;
  assign p17   = {1'b0, p_eff};
  assign goal  = p17 + {1'b0, unstable_r};

  wsa_arith #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_arith (
    .ctl      (ctl),
    .acc      (acc_r),
    .mcand    (mcand_r),
    .seed_sum (sum_r),
    .x        (x_r),
    .quo      (quo_r),
    .rem      (rem_r),
    .dbit     (acc_r[SW-1]),
    .period   (p_eff),
    .y        (y)
  );

  assign in_stall      = (state_r != S_IDLE) || !rst_n;
  assign out_valid     = out_valid_r;
  assign out_smoothed  = out_sm_r;
  assign out_out_index = out_idx_r;

  always_comb begin
    state_nxt     = state_r;
    period_nxt    = period_r;
    unstable_nxt  = unstable_r;
    seen_nxt      = seen_r;
    results_nxt   = results_r;
    avg_nxt       = avg_r;
    sum_nxt       = sum_r;
    out_valid_nxt = out_valid_r;
    out_sm_nxt    = out_sm_r;
    out_idx_nxt   = out_idx_r;
    x_nxt         = x_r;
    acc_nxt       = acc_r;
    mcand_nxt     = mcand_r;
    mplier_nxt    = mplier_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    cnt_nxt       = cnt_r;
    neg_nxt       = neg_r;
    emit_nxt      = emit_r;
    ctl           = '{op: OP_NONE, neg: 1'b0, mbit: 1'b0};

    if (cfg_we) begin
      case (cfg_index)
        REG_PERIOD:   period_nxt   = cfg_wdata;
        REG_UNSTABLE: unstable_nxt = cfg_wdata;
        default: ;
      endcase
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          x_nxt = in_sample;
          if (in_restart) begin
            seen_nxt    = '0;
            results_nxt = '0;
            avg_nxt     = '0;
            sum_nxt     = '0;
          end
          state_nxt = S_START;
        end
      end
      S_START: begin
        if (seen_r < p17) begin
          ctl.op   = OP_SEED;
          sum_nxt  = y[SUM_W-1:0];
          seen_nxt = seen_r + 1'b1;
          acc_nxt  = y[SUM_W-1:0];
          // seed complete: divide the sum, otherwise no result
          state_nxt = (seen_nxt == p17) ? S_MAG : S_IDLE;
        end else begin
          acc_nxt    = '0;
          mcand_nxt  = {{(SUM_W-SW){avg_r[SW-1]}}, avg_r};
          mplier_nxt = p_eff - 1'b1;
          cnt_nxt    = MUL_STEPS;
          state_nxt  = S_MUL;
          if (seen_r < goal) begin
            seen_nxt = seen_r + 1'b1;
          end
        end
        emit_nxt = !((seen_nxt < p17) || (seen_nxt < goal));
      end
      S_MUL: begin
        ctl.op     = OP_MAC;
        ctl.mbit   = mplier_r[0];
        acc_nxt    = y[SUM_W-1:0];
        mcand_nxt  = {mcand_r[SUM_W-2:0], 1'b0};
        mplier_nxt = {1'b0, mplier_r[PERIOD_W-1:1]};
        cnt_nxt    = cnt_r - 1'b1;
        if (cnt_r == {{(CNT_W-1){1'b0}}, 1'b1}) begin
          state_nxt = S_ADDX;
        end
      end
      S_ADDX: begin
        ctl.op    = OP_ADDX;
        acc_nxt   = y[SUM_W-1:0];
        state_nxt = S_MAG;
      end
      S_MAG: begin
        ctl.op    = OP_MAG;
        ctl.neg   = acc_r[SUM_W-1];
        neg_nxt   = acc_r[SUM_W-1];
        acc_nxt   = y[SUM_W-1:0];
        // top bits start the remainder; the quotient fits in SW bits
        rem_nxt   = y[SUM_W-1:SW];
        quo_nxt   = '0;
        cnt_nxt   = DIV_STEPS;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        ctl.op = OP_DIV;
        if (!y[ALU_W-1]) begin
          rem_nxt = y[PERIOD_W-1:0];
          quo_nxt = {quo_r[SW-2:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[PERIOD_W-2:0], acc_r[SW-1]};
          quo_nxt = {quo_r[SW-2:0], 1'b0};
        end
        acc_nxt = {acc_r[SUM_W-2:0], 1'b0};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == {{(CNT_W-1){1'b0}}, 1'b1}) begin
          state_nxt = S_NEG;
        end
      end
      S_NEG: begin
        ctl.op    = OP_NEG;
        ctl.neg   = neg_r;
        avg_nxt   = y[SW-1:0];
        state_nxt = emit_r ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_sm_nxt    = avg_r;
          out_idx_nxt   = results_r;
          if (results_r != '1) begin
            results_nxt = results_r + 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      period_r    <= PERIOD_RESET;
      unstable_r  <= UNSTABLE_RESET;
      seen_r      <= '0;
      results_r   <= '0;
      avg_r       <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      period_r    <= period_nxt;
      unstable_r  <= unstable_nxt;
      seen_r      <= seen_nxt;
      results_r   <= results_nxt;
      avg_r       <= avg_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_sm_r  <= out_sm_nxt;
    out_idx_r <= out_idx_nxt;
    x_r       <= x_nxt;
    acc_r     <= acc_nxt;
    mcand_r   <= mcand_nxt;
    mplier_r  <= mplier_nxt;
    rem_r     <= rem_nxt;
    quo_r     <= quo_nxt;
    cnt_r     <= cnt_nxt;
    neg_r     <= neg_nxt;
    emit_r    <= emit_nxt;
  end

  // remainder stays below the divisor through the whole division
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> ({1'b0, rem_r} < p17))
    else $error("divide remainder not below period");

  // an accepted request always starts the sequencer
  a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_START))
    else $error("accepted request did not start work");

  // after the sign step the block either emits or goes idle
  a_neg_next: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_NEG) |=> ((state_r == S_EMIT) || (state_r == S_IDLE)))
    else $error("bad state after sign step");

  // the output register is loaded only from the emit state
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r && (state_r != S_EMIT)) |=> !out_valid_r)
    else $error("result shown without emit");

endmodule

`default_nettype wire

/* test/tb.sv */
// tb: self-checking testbench for wilder_smoothing_average, with a scoreboard that predicts
// each smoothed value and index; depends on wsa_pkg and the block's rtl only
`timescale 1ns / 1ps

module tb;
  import wsa_pkg::*;

  localparam int SAMPLE_W = 32;
  localparam int RANDOM_ITEMS = 1000;
  localparam int QUIET_TAIL = 200;
  localparam int DRAIN_CYCLES = 80;
  localparam int HOLD_CYCLES = 300;
  localparam int LONG_PERIOD = 500;
  localparam int LONG_SERIES = LONG_PERIOD + 6;
  localparam longint CYCLE_LIMIT = 3_000_000;
  localparam logic signed [SAMPLE_W-1:0] MAX_S = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] MIN_S = {1'b1, {(SAMPLE_W-1){1'b0}}};

  class rma_scoreboard;
    logic [PERIOD_W-1:0] period_q;
    logic [PERIOD_W-1:0] unstable_q;
    logic signed [SAMPLE_W-1:0] average;
    longint seed_total;
    int unsigned taken;
    logic [INDEX_W-1:0] emitted;
    logic signed [SAMPLE_W-1:0] want_value[$];
    logic [INDEX_W-1:0] want_index[$];
    int errors;

    function new();
      period_q = PERIOD_RESET;
      unstable_q = UNSTABLE_RESET;
      errors = 0;
      start_series();
    endfunction

    function void start_series();
      average = '0;
      seed_total = 0;
      taken = 0;
      emitted = '0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [PERIOD_W-1:0] val);
      if (idx == REG_PERIOD) period_q = val;
      else if (idx == REG_UNSTABLE) unstable_q = val;
    endfunction

    // divide by p, nearest, ties away from zero
    function longint nearest_quotient(longint num, int unsigned p);
      longint unsigned mag;
      longint unsigned q;
      mag = (num < 0) ? longint'(-num) : num;
      q = (mag + p / 2) / p;
      return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    function void note_sample(logic signed [SAMPLE_W-1:0] s, logic restart);
      int unsigned p;
      int unsigned goal;
      longint x;
      p = (period_q == 0) ? 1 : period_q;
      goal = p + unstable_q;
      x = s;
      if (restart) start_series();
      if (taken < p) begin
        seed_total += x;
        taken++;
        if (taken == p) average = SAMPLE_W'(nearest_quotient(seed_total, p));
      end else begin
        average = SAMPLE_W'(nearest_quotient(x + longint'(p - 1) * average, p));
        if (taken < goal) taken++;
      end
      if (taken >= p && taken >= goal) begin
        want_value.push_back(average);
        want_index.push_back(emitted);
        if (emitted != '1) emitted++;
      end
    endfunction

    task report_error(string msg);
      if (errors < 100) $display("ERROR: %s", msg);
      errors++;
    endtask

    task check_result(logic signed [SAMPLE_W-1:0] v, logic [INDEX_W-1:0] idx);
      logic signed [SAMPLE_W-1:0] ev;
      logic [INDEX_W-1:0] ei;
      if (want_value.size() == 0) begin
        report_error($sformatf("unexpected result %h index %0d", v, idx));
        return;
      end
      ev = want_value.pop_front();
      ei = want_index.pop_front();
      if (v !== ev) report_error($sformatf("smoothed %h, expected %h (index %0d)", v, ev, ei));
      if (idx !== ei) report_error($sformatf("out_index %0d, expected %0d", idx, ei));
    endtask

    function int pending();
      return want_value.size();
    endfunction

    task check_drained();
      if (want_value.size() != 0)
        report_error($sformatf("%0d results never came out", want_value.size()));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic in_restart;
  logic out_valid;
  logic out_stall;
  logic signed [SAMPLE_W-1:0] out_smoothed;
  logic [INDEX_W-1:0] out_out_index;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [PERIOD_W-1:0] cfg_wdata;

  rma_scoreboard sb = new();
  bit idle_on = 1'b0;
  bit hold_req = 1'b0;
  int unsigned sent = 0;
  longint cycles = 0;

  wilder_smoothing_average #(.SAMPLE_WIDTH(SAMPLE_W)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_sample(in_sample),
    .in_restart(in_restart),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_smoothed(out_smoothed),
    .out_out_index(out_out_index),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_sample(in_sample, in_restart);
      if (out_valid && !out_stall) sb.check_result(out_smoothed, out_out_index);
    end
  end

  // receiver: short random stall bursts, or one long hold-off on demand
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return MAX_S;
      1: return MIN_S;
      2, 3: return $signed($urandom_range(0, 16)) - 8;
      default: return $urandom;
    endcase
  endfunction

  // valid stays high into the next request unless a gap is taken
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic restart);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= s;
    in_restart <= restart;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PERIOD_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // samples that give no result may still be in work after the last result
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0 || in_stall) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic signed [SAMPLE_W-1:0] opening [15];
    int unsigned rand_start;
    int unsigned p;
    int unsigned len;
    int unsigned n_series;
    bit fresh;
    bit hold_done;

    opening = '{MAX_S, MIN_S, MAX_S, MIN_S, -1, 0, 1, 32'sh5555_5555, 32'shAAAA_AAAA,
                MAX_S, MAX_S, MIN_S, 32'sh0001_8000, -32'sh0000_8000, MIN_S};
    hold_done = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_sample <= '0;
    in_restart <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= REG_PERIOD;
    cfg_wdata <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings, no restart on the first sample
    foreach (opening[k]) send_sample(opening[k], 1'b0);

    // period zero behaves as one
    settle();
    write_reg(REG_PERIOD, '0);
    write_reg(REG_UNSTABLE, '0);
    send_sample(MAX_S, 1'b1);
    send_sample(MIN_S, 1'b0);
    send_sample(-1, 1'b0);

    // rounding ties on negative values
    settle();
    write_reg(REG_PERIOD, 16'd2);
    write_reg(REG_UNSTABLE, 16'd1);
    send_sample(3, 1'b1);
    send_sample(-4, 1'b0);
    send_sample(0, 1'b0);
    send_sample(5, 1'b0);

    // settings changed mid-series: longest warm-up, then back, then a larger period re-seeds
    settle();
    write_reg(REG_UNSTABLE, '1);
    send_sample(7, 1'b0);
    send_sample(-9, 1'b0);
    settle();
    write_reg(REG_UNSTABLE, '0);
    send_sample(100, 1'b0);
    settle();
    write_reg(REG_PERIOD, 16'd8);
    send_sample(11, 1'b0);
    send_sample(12, 1'b0);
    send_sample(13, 1'b0);

    // long period, seed sum far above the sample range
    settle();
    write_reg(REG_PERIOD, PERIOD_W'(LONG_PERIOD));
    write_reg(REG_UNSTABLE, '0);
    for (int unsigned k = 0; k < LONG_SERIES; k++)
      send_sample(($urandom_range(0, 3) != 0) ? MAX_S : pick_sample(), k == 0);
    settle();
    write_reg(REG_PERIOD, 16'd3);

    rand_start = sent;
    while (sent - rand_start < RANDOM_ITEMS) begin
      settle();
      idle_on = (sent - rand_start < RANDOM_ITEMS - QUIET_TAIL) && ($urandom_range(0, 4) != 0);
      if (!hold_done && sent - rand_start > RANDOM_ITEMS / 3) begin
        // receiver holds off while samples keep coming, so the block backs up
        hold_done = 1'b1;
        write_reg(REG_PERIOD, 16'd1);
        write_reg(REG_UNSTABLE, '0);
        hold_req = 1'b1;
        for (int k = 0; k < 20; k++) send_sample(pick_sample(), k == 0);
        continue;
      end
      fresh = 1'b1;
      if ($urandom_range(0, 5) != 0) begin
        case ($urandom_range(0, 19))
          0: p = 0;
          1, 2: p = $urandom_range(17, 64);
          3, 4, 5, 6: p = $urandom_range(5, 16);
          default: p = $urandom_range(1, 4);
        endcase
        write_reg(REG_PERIOD, PERIOD_W'(p));
        write_reg(REG_UNSTABLE,
                  PERIOD_W'(($urandom_range(0, 2) == 0) ? $urandom_range(1, 5) : 0));
        // sometimes the old series carries on under the new settings
        fresh = $urandom_range(0, 7) != 0;
      end
      n_series = $urandom_range(1, 3);
      for (int unsigned s = 0; s < n_series; s++) begin
        p = (sb.period_q == 0) ? 1 : sb.period_q;
        len = p + sb.unstable_q + $urandom_range(0, 12);
        if ($urandom_range(0, 6) == 0) len = $urandom_range(1, len);
        for (int unsigned k = 0; k < len; k++)
          send_sample(pick_sample(), (k == 0 && (fresh || s > 0)) || ($urandom_range(0, 60) == 0));
      end
    end

    idle_on = 1'b0;
    settle();
    sb.check_drained();
    if (sb.errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
